// ----- src/u16da_pkg.sv -----
package u16da_pkg;

  localparam int BinW   = 16;
  localparam int NumPos = 5;
  localparam int BcdW   = 4 * NumPos;
  localparam int DdW    = BcdW + BinW;

  // Double-dabble steps done in each pipeline stage; stages times steps covers BinW
  localparam int StepsPerStage = 4;
  localparam int NumStages     = BinW / StepsPerStage;

  // Each decimal position owns three character slots: '.', digit, pad zero
  localparam int SlotsPerPos = 3;
  localparam int SlotW       = SlotsPerPos * NumPos;
  localparam int SlotDot     = 0;
  localparam int SlotDigit   = 1;
  localparam int SlotPad     = 2;

  // Position index of the tens digit, where the decimal point goes
  localparam int DotPos      = 3;
  // Positions past this index emit a forced zero in decimal mode
  localparam int FracZeroPos = 1;

  localparam logic [2:0] MaxPad    = 3'd5;
  localparam logic [3:0] PadLimit  = 4'd5;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharDot   = 8'd46;
  localparam logic [3:0] DigitHigh = 4'b0011;

  typedef struct packed {
    logic [DdW-1:0] dd;
    logic           dec;
    logic [2:0]     width;
  } stage_t;

  // One shift-and-add-3 step of binary to BCD conversion
  function automatic logic [DdW-1:0] dd_step(input logic [DdW-1:0] x);
    logic [DdW-1:0] y;
    y = x;
    for (int n = 0; n < NumPos; n++) begin
      if (y[BinW + 4*n +: 4] >= 4'd5) begin
        y[BinW + 4*n +: 4] = y[BinW + 4*n +: 4] + 4'd3;
      end
    end
    return {y[DdW-2:0], 1'b0};
  endfunction

endpackage

// ----- src/uint16_to_decimal_ascii_unit.sv -----
// Path: an accepted item passes through the conversion stage registers and is then
//   loaded into the serializer; its first character leaves when out_stall is low.
// Throughput: one character per cycle while out_stall is low; the serializer takes
//   the next item as the last character goes, and drops items with no characters.
// Reset: synchronous, active low; clears all stage valid bits and busy_r.
module uint16_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_value,
  input  logic        in_decimal_mode,
  input  logic [2:0]  in_pad_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_code,
  output logic        out_last
);

  localparam int NS = u16da_pkg::NumStages;

  // Stage links: index 0 is the input side, index NS feeds the serializer
  logic              s_valid [NS+1];
  logic              s_ready [NS+1];
  u16da_pkg::stage_t s_data  [NS+1];

  // Seed the conversion word with the binary value and clamp the pad width to five
  assign s_valid[0]      = in_valid;
  assign s_data[0].dd    = {{u16da_pkg::BcdW{1'b0}}, in_value};
  assign s_data[0].dec   = in_decimal_mode;
  assign s_data[0].width = (in_pad_width > u16da_pkg::MaxPad) ? u16da_pkg::MaxPad
                                                             : in_pad_width;
  assign in_stall        = !s_ready[0];

  // Four equal stages of four double-dabble steps each
  for (genvar g = 0; g < NS; g++) begin : g_stage
    u16da_bcd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (s_valid[g]),
      .up_ready (s_ready[g]),
      .up_data  (s_data[g]),
      .dn_valid (s_valid[g+1]),
      .dn_ready (s_ready[g+1]),
      .dn_data  (s_data[g+1])
    );
  end

  // Expand BCD digits to characters; transfer one per cycle while out_stall is low
  u16da_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (s_valid[NS]),
    .up_ready      (s_ready[NS]),
    .up_data       (s_data[NS]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  // Only digits and the decimal point ever leave the block
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code >= u16da_pkg::CharZero &&
                    out_char_code <= (u16da_pkg::CharZero + 8'd9)) ||
                   out_char_code == u16da_pkg::CharDot))
    else $error("character outside digit and point set");

  // A transferred character that is not last leaves more to send
  a_more_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("item ended without last flag");

  // An accepted input enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s_valid[1])
    else $error("accepted input lost at first stage");

endmodule

// ----- src/u16da_bcd_stage.sv -----
module u16da_bcd_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  u16da_pkg::stage_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output u16da_pkg::stage_t  dn_data
);

  logic              valid_r;
  u16da_pkg::stage_t data_r;
  u16da_pkg::stage_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Run this stage's share of the conversion steps
  always_comb begin
    data_nxt = up_data;
    for (int s = 0; s < u16da_pkg::StepsPerStage; s++) begin
      data_nxt.dd = u16da_pkg::dd_step(data_nxt.dd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/u16da_serializer.sv -----
module u16da_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  u16da_pkg::stage_t up_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char_code,
  output logic              out_last
);

  logic                            busy_r;
  logic [u16da_pkg::SlotW-1:0]     mask_r;
  logic [u16da_pkg::BcdW-1:0]      bcd_r;
  logic [u16da_pkg::SlotW-1:0]     new_mask;
  logic [u16da_pkg::SlotW-1:0]     sel;
  logic [u16da_pkg::SlotW-1:0]     rest;
  logic                            lead;
  logic [3:0]                      dgt;
  logic                            load;

  // Build the slot mask: which of the fifteen characters this item emits
  always_comb begin
    new_mask = '0;
    lead     = 1'b1;
    dgt      = '0;
    for (int p = 0; p < u16da_pkg::NumPos; p++) begin
      dgt  = up_data.dd[u16da_pkg::BinW + 4*(u16da_pkg::NumPos-1-p) +: 4];
      lead = lead && (dgt == 4'd0);
      new_mask[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotDot] =
        up_data.dec && (p == u16da_pkg::DotPos);
      new_mask[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotDigit] =
        !lead || (up_data.dec && (p > u16da_pkg::FracZeroPos));
      new_mask[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotPad] =
        lead && (({1'b0, up_data.width} + 4'(p)) >= u16da_pkg::PadLimit);
    end
  end

  assign sel  = mask_r & (~mask_r + {{(u16da_pkg::SlotW-1){1'b0}}, 1'b1});
  assign rest = mask_r & (mask_r - {{(u16da_pkg::SlotW-1){1'b0}}, 1'b1});

  // Pick the character of the lowest pending slot
  always_comb begin
    out_char_code = '0;
    for (int p = 0; p < u16da_pkg::NumPos; p++) begin
      if (sel[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotDot]) begin
        out_char_code = out_char_code | u16da_pkg::CharDot;
      end
      if (sel[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotDigit]) begin
        out_char_code = out_char_code |
          {u16da_pkg::DigitHigh, bcd_r[4*(u16da_pkg::NumPos-1-p) +: 4]};
      end
      if (sel[p*u16da_pkg::SlotsPerPos + u16da_pkg::SlotPad]) begin
        out_char_code = out_char_code | u16da_pkg::CharZero;
      end
    end
  end

  assign out_valid = busy_r;
  assign out_last  = (rest == '0);
  assign up_ready  = !busy_r || (!out_stall && out_last);
  // Drop items with nothing to emit
  assign load      = up_valid && up_ready && (new_mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (busy_r && !out_stall) begin
      busy_r <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask_r <= new_mask;
      bcd_r  <= up_data.dd[u16da_pkg::DdW-1:u16da_pkg::BinW];
    end else if (busy_r && !out_stall) begin
      mask_r <= rest;
    end
  end

endmodule
